// File: sv/iqbq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iqbq_pkg
// Shared widths, register indexes and rounding constants for the IQ biquad
// pair with magnitude.
// ----------------------------------------------------------------------------
package iqbq_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 32;
  localparam int MAG_W     = 16;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 4;
  localparam int REG_SEL_W = $clog2(NUM_REGS);
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int ACC_W     = PROD_W + 3;
  localparam int FRAC_W    = 30;
  localparam int RND_W     = ACC_W - FRAC_W;
  localparam int RAD_W     = 2 * MAG_W;
  localparam int REM_W     = MAG_W + 4;
  localparam int CNT_W     = 4;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);

  localparam logic [REG_SEL_W-1:0] REG_IB0 = REG_SEL_W'(0);
  localparam logic [REG_SEL_W-1:0] REG_IB1 = REG_SEL_W'(1);
  localparam logic [REG_SEL_W-1:0] REG_IB2 = REG_SEL_W'(2);
  localparam logic [REG_SEL_W-1:0] REG_QB0 = REG_SEL_W'(3);
  localparam logic [REG_SEL_W-1:0] REG_QB1 = REG_SEL_W'(4);
  localparam logic [REG_SEL_W-1:0] REG_QB2 = REG_SEL_W'(5);
  localparam logic [REG_SEL_W-1:0] REG_FA1 = REG_SEL_W'(6);
  localparam logic [REG_SEL_W-1:0] REG_FA2 = REG_SEL_W'(7);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic [MAG_W-1:0]           mag_t;

endpackage

`default_nettype wire

// File: sv/iqbq_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iqbq channel interfaces
// Valid/ready channels for input samples and for IQ results with magnitude.
// ----------------------------------------------------------------------------
interface sample_if;
  import iqbq_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface result_if;
  import iqbq_pkg::*;

  logic    valid;
  logic    ready;
  sample_t inphase_out;
  sample_t quad_out;
  mag_t    magnitude;

  modport source (output valid, output inphase_out, output quad_out, output magnitude,
                  input ready);
  modport sink (input valid, input inphase_out, input quad_out, input magnitude,
                output ready);
endinterface

`default_nettype wire

// File: sv/iq_biquad_pair_magnitude.sv
// A new sample request is accepted only after the previous result is loaded into
// the output register. The single 16x32 multiplier runs 12 products (10 filter
// taps, 2 squares), then the square root resolves one bit per cycle.
// Reset clears coefficients, delay lines, sequencer and output valid.
`default_nettype none
// ----------------------------------------------------------------------------
// iq_biquad_pair_magnitude
// Two direct form I biquads sharing input delay and feedback coefficients, giving
// in-phase and quadrature outputs and their integer magnitude.
// ----------------------------------------------------------------------------
module iq_biquad_pair_magnitude (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [iqbq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [iqbq_pkg::COEF_W-1:0]    cfg_data,
  sample_if.sink                         sample_ch,
  result_if.source                       result_ch
);
  import iqbq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MAC  = 2'd1;
  localparam logic [1:0] S_ROOT = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  localparam logic [CNT_W-1:0] ST_XI     = CNT_W'(0);
  localparam logic [CNT_W-1:0] ST_D1I    = CNT_W'(1);
  localparam logic [CNT_W-1:0] ST_D2I    = CNT_W'(2);
  localparam logic [CNT_W-1:0] ST_Y1I    = CNT_W'(3);
  localparam logic [CNT_W-1:0] ST_Y2I    = CNT_W'(4);
  localparam logic [CNT_W-1:0] ST_XQ     = CNT_W'(5);
  localparam logic [CNT_W-1:0] ST_D1Q    = CNT_W'(6);
  localparam logic [CNT_W-1:0] ST_D2Q    = CNT_W'(7);
  localparam logic [CNT_W-1:0] ST_Y1Q    = CNT_W'(8);
  localparam logic [CNT_W-1:0] ST_Y2Q    = CNT_W'(9);
  localparam logic [CNT_W-1:0] ST_SQI    = CNT_W'(10);
  localparam logic [CNT_W-1:0] ST_SQQ    = CNT_W'(11);
  localparam logic [CNT_W-1:0] ST_END    = CNT_W'(12);
  localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(MAG_W - 1);

  logic [1:0]       state;
  logic [CNT_W-1:0] cnt;
  coef_t            coef [NUM_REGS];

  sample_t x, d1, d2, yi1, yi2, yq1, yq2, yi, yq;

  sample_t                   mul_a;
  coef_t                     mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   acc_sum;
  logic signed [ACC_W-1:0]   rnd_full;
  logic [RND_W-1:0]          rnd;
  logic                      sat_hi, sat_lo;
  sample_t                   sat_val;
  logic [CNT_W-1:0]          acc_idx;
  logic                      acc_sub;

  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem, rem2, trial;
  mag_t             root;
  logic             root_ge;

  logic    out_valid;
  sample_t out_inphase, out_quad;
  mag_t    out_mag;
  logic    accept, load;

  assign sample_ch.ready       = (state == S_IDLE);
  assign accept                = sample_ch.valid && sample_ch.ready;
  assign load                  = (state == S_HOLD) && (!out_valid || result_ch.ready);
  assign result_ch.valid       = out_valid;
  assign result_ch.inphase_out = out_inphase;
  assign result_ch.quad_out    = out_quad;
  assign result_ch.magnitude   = out_mag;

  always_comb begin
    case (cnt)
      ST_XI: begin
        mul_a = x;   mul_b = coef[REG_IB0];
      end
      ST_D1I: begin
        mul_a = d1;  mul_b = coef[REG_IB1];
      end
      ST_D2I: begin
        mul_a = d2;  mul_b = coef[REG_IB2];
      end
      ST_Y1I: begin
        mul_a = yi1; mul_b = coef[REG_FA1];
      end
      ST_Y2I: begin
        mul_a = yi2; mul_b = coef[REG_FA2];
      end
      ST_XQ: begin
        mul_a = x;   mul_b = coef[REG_QB0];
      end
      ST_D1Q: begin
        mul_a = d1;  mul_b = coef[REG_QB1];
      end
      ST_D2Q: begin
        mul_a = d2;  mul_b = coef[REG_QB2];
      end
      ST_Y1Q: begin
        mul_a = yq1; mul_b = coef[REG_FA1];
      end
      ST_Y2Q: begin
        mul_a = yq2; mul_b = coef[REG_FA2];
      end
      ST_SQI: begin
        mul_a = yi;  mul_b = {{(COEF_W-SAMPLE_W){yi[SAMPLE_W-1]}}, yi};
      end
      ST_SQQ: begin
        mul_a = yq;  mul_b = {{(COEF_W-SAMPLE_W){yq[SAMPLE_W-1]}}, yq};
      end
      default: begin
        mul_a = '0;  mul_b = '0;
      end
    endcase
  end

  always_comb begin
    acc_idx  = cnt - CNT_W'(1);
    acc_sub  = (acc_idx == ST_Y1I) || (acc_idx == ST_Y2I) ||
               (acc_idx == ST_Y1Q) || (acc_idx == ST_Y2Q);
    prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    acc_sum  = acc + (acc_sub ? -prod_ext : prod_ext);
    rnd_full = acc_sum + ROUND_HALF;
    rnd      = rnd_full[ACC_W-1:FRAC_W];
    sat_hi   = !rnd[RND_W-1] && (|rnd[RND_W-2:SAMPLE_W-1]);
    sat_lo   = rnd[RND_W-1] && !(&rnd[RND_W-2:SAMPLE_W-1]);
    if (sat_hi) begin
      sat_val = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (sat_lo) begin
      sat_val = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sat_val = rnd[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    rem2    = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
    trial   = {{(REM_W-MAG_W-2){1'b0}}, root, 2'b01};
    root_ge = (rem2 >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coef[i] <= '0;
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      coef[cfg_index[REG_SEL_W-1:0]] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      d1        <= '0;
      d2        <= '0;
      yi1       <= '0;
      yi2       <= '0;
      yq1       <= '0;
      yq2       <= '0;
    end else begin
      if (result_ch.valid && result_ch.ready && !load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            x     <= sample_ch.sample_in;
            acc   <= '0;
            cnt   <= ST_XI;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          prod <= mul_a * mul_b;
          if (cnt != ST_XI) begin
            if (acc_idx == ST_Y2I) begin
              yi  <= sat_val;
              acc <= '0;
            end else if (acc_idx == ST_Y2Q) begin
              yq  <= sat_val;
              acc <= '0;
            end else begin
              acc <= acc_sum;
            end
          end
          if (cnt == ST_END) begin
            rad   <= acc_sum[RAD_W-1:0];
            rem   <= '0;
            root  <= '0;
            d2    <= d1;
            d1    <= x;
            yi2   <= yi1;
            yi1   <= yi;
            yq2   <= yq1;
            yq1   <= yq;
            cnt   <= '0;
            state <= S_ROOT;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        S_ROOT: begin
          rad  <= {rad[RAD_W-3:0], 2'b00};
          rem  <= root_ge ? (rem2 - trial) : rem2;
          root <= {root[MAG_W-2:0], root_ge};
          cnt  <= cnt + CNT_W'(1);
          if (cnt == ROOT_LAST) begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (load) begin
            out_inphase <= yi;
            out_quad    <= yq;
            out_mag     <= root;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    sample_ch.valid && sample_ch.ready |=> state == S_MAC && cnt == ST_XI)
    else $error("accepted sample did not start the product sequence");

  a_mac_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_MAC |-> cnt <= ST_END)
    else $error("product counter ran past the last step");

  a_root_done: assert property (@(posedge clk) disable iff (rst)
    state == S_ROOT && cnt == ROOT_LAST |=> state == S_HOLD)
    else $error("root did not finish after its last bit");

  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    result_ch.valid |-> result_ch.magnitude <= MAG_W'(46340))
    else $error("magnitude out of range");

endmodule

`default_nettype wire

// File: tb/sv/tb_iq_biquad_pair_magnitude.sv
// ----------------------------------------------------------------------------
// tb_iq_biquad_pair_magnitude
// Self-checking bench for the IQ biquad pair. A scoreboard keeps its own copy
// of the coefficients, delay lines and feedback history, predicts in-phase,
// quadrature and magnitude for every accepted sample request, and compares
// each taken result in order. Directed items cover rounding of halves,
// saturation both ways, the delay and feedback taps and writes to unused
// register indexes; random phases follow under varied idling, with one long
// receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_iq_biquad_pair_magnitude;
  import iqbq_pkg::*;

  localparam int     LIMIT      = 500000;
  localparam int     TAIL       = 40;
  localparam int     SHOW_MAX   = 40;
  localparam sample_t SMP_MAX   = 16'sh7FFF;
  localparam sample_t SMP_MIN   = 16'sh8000;
  localparam coef_t  COEF_MAX   = 32'sh7FFF_FFFF;
  localparam coef_t  COEF_MIN   = 32'sh8000_0000;
  localparam coef_t  ONE_Q30    = 32'sh4000_0000;
  localparam coef_t  HALF_Q30   = 32'sh2000_0000;
  localparam logic [CFG_IDX_W-1:0] UNUSED_LO = CFG_IDX_W'(NUM_REGS);
  localparam logic [CFG_IDX_W-1:0] UNUSED_HI = '1;

  typedef struct {
    sample_t inphase;
    sample_t quad;
    mag_t    mag;
  } iq_result_t;

  class iq_scoreboard;
    coef_t      coef [NUM_REGS];
    sample_t    x_d1, x_d2, i_d1, i_d2, q_d1, q_d2;
    iq_result_t expected_q[$];
    int         errors;

    function void clear();
      foreach (coef[k]) coef[k] = '0;
      x_d1 = '0; x_d2 = '0;
      i_d1 = '0; i_d2 = '0;
      q_d1 = '0; q_d2 = '0;
      expected_q.delete();
      errors = 0;
    endfunction

    function void write_coef(logic [CFG_IDX_W-1:0] idx, coef_t value);
      if (idx < NUM_REGS) coef[idx[REG_SEL_W-1:0]] = value;
    endfunction

    function sample_t biquad(sample_t x, coef_t b0, coef_t b1, coef_t b2,
                             sample_t y1, sample_t y2);
      longint acc;
      longint r;
      acc = longint'(x) * longint'(b0) + longint'(x_d1) * longint'(b1)
          + longint'(x_d2) * longint'(b2)
          - longint'(y1) * longint'(coef[REG_FA1])
          - longint'(y2) * longint'(coef[REG_FA2]);
      r = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
      if (r > longint'(SMP_MAX)) r = longint'(SMP_MAX);
      if (r < longint'(SMP_MIN)) r = longint'(SMP_MIN);
      return sample_t'(r);
    endfunction

    function mag_t int_sqrt(longint n);
      mag_t r;
      mag_t trial;
      r = '0;
      for (int b = MAG_W - 1; b >= 0; b--) begin
        trial = r | (mag_t'(1) << b);
        if (longint'(trial) * longint'(trial) <= n) r = trial;
      end
      return r;
    endfunction

    function void note_sample(sample_t x);
      iq_result_t e;
      e.inphase = biquad(x, coef[REG_IB0], coef[REG_IB1], coef[REG_IB2], i_d1, i_d2);
      e.quad    = biquad(x, coef[REG_QB0], coef[REG_QB1], coef[REG_QB2], q_d1, q_d2);
      e.mag     = int_sqrt(longint'(e.inphase) * e.inphase + longint'(e.quad) * e.quad);
      i_d2 = i_d1; i_d1 = e.inphase;
      q_d2 = q_d1; q_d1 = e.quad;
      x_d2 = x_d1; x_d1 = x;
      expected_q.push_back(e);
    endfunction

    task report(string msg);
      if (errors < SHOW_MAX) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(sample_t inphase, sample_t quad, mag_t mag);
      iq_result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d/%0d/%0d with no request pending", inphase, quad, mag));
      end else begin
        e = expected_q.pop_front();
        if (inphase !== e.inphase)
          report($sformatf("inphase_out %0d, want %0d", inphase, e.inphase));
        if (quad !== e.quad)
          report($sformatf("quad_out %0d, want %0d", quad, e.quad));
        if (mag !== e.mag)
          report($sformatf("magnitude %0d, want %0d", mag, e.mag));
      end
    endtask
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COEF_W-1:0]    cfg_data;

  sample_if smp ();
  result_if res ();

  iq_biquad_pair_magnitude dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample_ch (smp),
    .result_ch (res)
  );

  iq_scoreboard sb;
  int           stall_pct;
  int           hold_left;
  int           cycles;
  coef_t        cset [NUM_REGS];
  sample_t      items[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    smp.valid     = 1'b0;
    smp.sample_in = '0;
    res.ready     = 1'b0;
    stall_pct     = 0;
    hold_left     = 0;
    cycles        = 0;
    sb            = new();
    sb.clear();
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("iq_biquad_pair_magnitude regression: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      res.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      res.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready)
      sb.check_result(res.inphase_out, res.quad_out, res.magnitude);
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input coef_t value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.write_coef(idx, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_coefs();
    for (int k = 0; k < NUM_REGS; k++) write_reg(CFG_IDX_W'(k), cset[k]);
  endtask

  task automatic play(input int idle_pct);
    foreach (items[k]) begin
      @(negedge clk);
      while ($urandom_range(0, 99) < idle_pct) begin
        smp.valid <= 1'b0;
        @(negedge clk);
      end
      smp.valid     <= 1'b1;
      smp.sample_in <= items[k];
      do @(posedge clk); while (smp.ready !== 1'b1);
      sb.note_sample(items[k]);
    end
    @(negedge clk);
    smp.valid <= 1'b0;
    items.delete();
  endtask

  task automatic drain();
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2:       return sample_t'($signed($urandom_range(0, 511)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic coef_t rand_coef();
    case ($urandom_range(0, 7))
      0:       return COEF_MAX;
      1:       return COEF_MIN;
      2:       return '0;
      3, 4:    return coef_t'($signed($urandom) >>> 1);
      default: return coef_t'($urandom);
    endcase
  endfunction

  task automatic random_phase(input int n, input int idle_pct, input int stall,
                              input int fb_kind);
    drain();
    foreach (cset[k]) cset[k] = rand_coef();
    if (fb_kind == 0) begin
      foreach (cset[k]) cset[k] = coef_t'($signed($urandom) >>> 2);
      cset[REG_FA1] = coef_t'(longint'(-1.968424561991035 * 1073741824.0));
      cset[REG_FA2] = coef_t'(longint'(0.969376917213154 * 1073741824.0));
    end else if (fb_kind == 1) begin
      cset[REG_FA1] = '0;
      cset[REG_FA2] = '0;
    end
    load_coefs();
    stall_pct = stall;
    repeat (n) items.push_back(rand_sample());
    play(idle_pct);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    items = '{SMP_MAX, SMP_MIN, 16'sd0, -16'sd1};
    play(0);

    drain();
    foreach (cset[k]) cset[k] = '0;
    cset[REG_IB0] = HALF_Q30;
    cset[REG_QB0] = -HALF_Q30;
    load_coefs();
    write_reg(UNUSED_LO, COEF_MAX);
    write_reg(UNUSED_HI, COEF_MIN);
    items = '{16'sd1, -16'sd1, 16'sd3, -16'sd3, SMP_MAX, SMP_MIN};
    play(0);

    drain();
    cset[REG_IB0] = '0;
    cset[REG_IB1] = ONE_Q30;
    cset[REG_IB2] = -ONE_Q30;
    cset[REG_QB0] = ONE_Q30;
    cset[REG_QB1] = '0;
    cset[REG_QB2] = HALF_Q30;
    cset[REG_FA1] = -HALF_Q30;
    cset[REG_FA2] = HALF_Q30;
    load_coefs();
    items = '{16'sd1000, -16'sd77, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    play(0);

    drain();
    cset[REG_IB0] = COEF_MAX;
    cset[REG_IB1] = COEF_MIN;
    cset[REG_IB2] = COEF_MAX;
    cset[REG_QB0] = COEF_MIN;
    cset[REG_QB1] = COEF_MAX;
    cset[REG_QB2] = COEF_MIN;
    cset[REG_FA1] = COEF_MIN;
    cset[REG_FA2] = COEF_MAX;
    load_coefs();
    items = '{SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN, 16'sd0, 16'sd0};
    play(0);

    random_phase(170, 0, 0, 0);
    random_phase(170, 71, 0, 2);
    random_phase(170, 0, 71, 1);
    random_phase(170, 38, 38, 0);
    drain();
    hold_left = 400;
    random_phase(170, 0, 0, 2);

    drain();
    repeat (TAIL) @(posedge clk);
    if (sb.errors == 0) begin
      $display("iq_biquad_pair_magnitude regression: pass");
    end else begin
      $display("iq_biquad_pair_magnitude regression: fail");
    end
    $finish;
  end

endmodule
